/* design/hscl_pkg.sv */
// ----------------------------------------------------------------------------
// hscl_pkg
// Shared types and constants for the hashed source cache lookup block.
// ----------------------------------------------------------------------------
package hscl_pkg;

  // Field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 7;

  // Input function codes
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_STORE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result kind codes
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Hash and mix constants
  localparam logic [KEY_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [KEY_W-1:0] KEY_TOP   = 64'h8000000000000000;
  localparam logic [31:0]      MIX_MULT  = 32'h5bd1e995;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_STORE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage

/* design/hscl_ram.sv */
// ----------------------------------------------------------------------------
// hscl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hscl_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hscl_fifo.sv */
// ----------------------------------------------------------------------------
// hscl_fifo
// Short command queue that decouples the hashing front from the table back.
// ----------------------------------------------------------------------------
module hscl_fifo
  import hscl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o,
  output logic full_o
);

  localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entry_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(CMDQ_DEPTH));
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/hscl_front.sv */
// ----------------------------------------------------------------------------
// hscl_front
// Accepts beats, folds source bytes into the FNV-1a hash and queues commands.
// ----------------------------------------------------------------------------
module hscl_front
  import hscl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  logic [KEY_W-1:0] hash_q, hash_d;
  logic [KEY_W-1:0] mixed_in, hash_next;

  // FNV-1a step; the prime is 2^40 + 0x1b3, so the product is shifts and adds
  assign mixed_in  = hash_q ^ {56'd0, data_byte_i};
  assign hash_next = (mixed_in << 40) + (mixed_in << 8) + (mixed_in << 7)
                   + (mixed_in << 5) + (mixed_in << 4) + (mixed_in << 1) + mixed_in;

  // classify the beat
  always_comb begin
    hash_d        = hash_q;
    push_o        = 1'b0;
    cmd_o.op      = OP_LOOKUP;
    cmd_o.key     = hash_next | KEY_TOP;
    cmd_o.handle  = handle_i;
    if (accept_i) begin
      case (func_i)
        FUNC_BYTE: begin
          if (last_i) begin
            hash_d = FNV_BASIS;
            push_o = 1'b1;
          end else begin
            hash_d = hash_next;
          end
        end
        FUNC_STORE: begin
          cmd_o.op = OP_STORE;
          push_o   = 1'b1;
        end
        FUNC_CLEAR: begin
          cmd_o.op = OP_CLEAR;
          push_o   = 1'b1;
        end
        default: ; // unused code: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

/* design/hscl_back.sv */
// ----------------------------------------------------------------------------
// hscl_back
// Mixes keys to a start slot, probes the table, stores and clears entries.
// ----------------------------------------------------------------------------
module hscl_back
  import hscl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128,
  parameter int unsigned HANDLE_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  output logic                init_o,
  output logic                res_strobe_o,
  output logic [1:0]          kind_o,
  output logic                hit_o,
  output logic                table_full_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [HANDLE_W-1:0] found_handle_o,
  output logic                stored_o
);

  localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned REM_W    = IDX_W + 1;
  localparam int unsigned ROW_W    = KEY_W + HANDLE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [REM_W-1:0] MODULUS  = REM_W'(TABLE_ENTRIES);
  localparam logic [31:0] MOD32    = 32'(TABLE_ENTRIES);
  // floor(2^32 / table size): estimated quotient is exact or one short
  localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_QUO,
    ST_REM,
    ST_FIX,
    ST_RD,
    ST_CMP,
    ST_CLR
  } state_e;

  state_e           state_q;
  logic [31:0]      mix_q;
  logic [31:0]      quo_q;
  logic [REM_W-1:0] rem_q;
  logic [IDX_W-1:0] cur_q, cnt_q;
  logic [KEY_W-1:0] key_q, pend_key_q;
  logic [IDX_W-1:0] pend_slot_q;
  logic             pend_ok_q;
  logic             clr_ack_q;

  logic [31:0]      fold_in;
  logic [63:0]      quo_prod;
  logic [31:0]      rem_full;
  logic [REM_W-1:0] rem_fix;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [HANDLE_BITS-1:0] rd_handle, wr_handle;
  logic [HANDLE_BITS+HANDLE_W-1:0] wr_ext;
  logic [HANDLE_W+HANDLE_BITS-1:0] rd_ext;
  logic [IDX_W+SLOT_W-1:0] cur_ext, pend_ext;
  logic             key_match, slot_empty;

  assign fold_in  = cmd_i.key[31:0] ^ cmd_i.key[63:32];
  assign rd_key   = ram_rdata[ROW_W-1:HANDLE_BITS];
  assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
  assign wr_ext   = {{HANDLE_BITS{1'b0}}, cmd_i.handle};
  assign wr_handle = wr_ext[HANDLE_BITS-1:0];
  assign rd_ext   = {{HANDLE_W{1'b0}}, rd_handle};
  assign cur_ext  = {{SLOT_W{1'b0}}, cur_q};
  assign pend_ext = {{SLOT_W{1'b0}}, pend_slot_q};
  assign key_match  = (rd_key == key_q);
  assign slot_empty = (rd_key == '0);

  assign pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign init_o = (state_q == ST_CLR) && !clr_ack_q;

  // remainder by the table size: reciprocal quotient, back-multiply, one fix-up
  assign quo_prod = {32'd0, mix_q} * {32'd0, RECIP};
  assign rem_full = mix_q - quo_q * MOD32;
  assign rem_fix  = (rem_q >= MODULUS) ? rem_q - MODULUS : rem_q;

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_re    = (state_q == ST_RD);
    if (state_q == ST_CLR) begin
      ram_we = 1'b1;
    end else if (pop_o && cmd_i.op == OP_STORE && pend_ok_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_slot_q;
      ram_wdata = {pend_key_q, wr_handle};
    end
  end

  hscl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  // sequencer, pending state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLR;
      cur_q          <= '0;
      cnt_q          <= '0;
      clr_ack_q      <= 1'b0;
      pend_key_q     <= '0;
      pend_slot_q    <= '0;
      pend_ok_q      <= 1'b0;
      res_strobe_o   <= 1'b0;
      kind_o         <= KIND_LOOKUP;
      hit_o          <= 1'b0;
      table_full_o   <= 1'b0;
      slot_index_o   <= '0;
      found_handle_o <= '0;
      stored_o       <= 1'b0;
    end else begin
      res_strobe_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_LOOKUP: begin
                key_q   <= cmd_i.key;
                mix_q   <= fold_in ^ (fold_in >> 13);
                state_q <= ST_MUL;
              end
              OP_STORE: begin
                res_strobe_o   <= 1'b1;
                kind_o         <= KIND_STORE;
                hit_o          <= 1'b0;
                table_full_o   <= 1'b0;
                slot_index_o   <= pend_ext[SLOT_W-1:0];
                found_handle_o <= '0;
                stored_o       <= pend_ok_q;
              end
              OP_CLEAR: begin
                pend_ok_q <= 1'b0;
                clr_ack_q <= 1'b1;
                cur_q     <= '0;
                state_q   <= ST_CLR;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          mix_q   <= mix_q * MIX_MULT;
          state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          mix_q   <= mix_q ^ (mix_q >> 15);
          state_q <= ST_QUO;
        end
        ST_QUO: begin
          quo_q   <= quo_prod[63:32];
          state_q <= ST_REM;
        end
        ST_REM: begin
          // below twice the table size, so the low bits hold it exactly
          rem_q   <= rem_full[REM_W-1:0];
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          cur_q   <= rem_fix[IDX_W-1:0];
          cnt_q   <= '0;
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (key_match || slot_empty) begin
            // matching or free slot found
            res_strobe_o   <= 1'b1;
            kind_o         <= KIND_LOOKUP;
            hit_o          <= key_match && (rd_handle != '0);
            table_full_o   <= 1'b0;
            slot_index_o   <= cur_ext[SLOT_W-1:0];
            found_handle_o <= (key_match && (rd_handle != '0)) ?
                              rd_ext[HANDLE_W-1:0] : '0;
            stored_o       <= 1'b0;
            pend_key_q     <= key_q;
            pend_slot_q    <= cur_q;
            pend_ok_q      <= 1'b1;
            state_q        <= ST_IDLE;
          end else if (cnt_q == LAST_IDX) begin
            // every slot walked: table full
            res_strobe_o   <= 1'b1;
            kind_o         <= KIND_LOOKUP;
            hit_o          <= 1'b0;
            table_full_o   <= 1'b1;
            slot_index_o   <= '0;
            found_handle_o <= '0;
            stored_o       <= 1'b0;
            pend_key_q     <= key_q;
            pend_slot_q    <= '0;
            pend_ok_q      <= 1'b0;
            state_q        <= ST_IDLE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            cur_q   <= (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_CLR: begin
          if (cur_q == LAST_IDX) begin
            cur_q   <= '0;
            state_q <= ST_IDLE;
            if (clr_ack_q) begin
              res_strobe_o   <= 1'b1;
              kind_o         <= KIND_CLEAR;
              hit_o          <= 1'b0;
              table_full_o   <= 1'b0;
              slot_index_o   <= '0;
              found_handle_o <= '0;
              stored_o       <= 1'b0;
            end
          end else begin
            cur_q <= cur_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/hashed_source_cache_lookup.sv */
// Operation: a source byte not marked last gives no result.
// A lookup pops the queue, mixes the key and takes the remainder, then reads and
// compares each probed slot in turn (one table read port) before its result; a store
// is acknowledged once the idle back pops it, and a clear after its sweep of the table.
// Bytes are taken one per cycle while the back works, until the 2-entry queue fills.
// Reset: the table is swept to empty, busy high.
// ----------------------------------------------------------------------------
// hashed_source_cache_lookup
// Top level: hashing front, command queue and table back end.
// ----------------------------------------------------------------------------
module hashed_source_cache_lookup
  import hscl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128,
  parameter int unsigned HANDLE_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                res_strobe_o,
  output logic [1:0]          kind_o,
  output logic                hit_o,
  output logic                table_full_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [HANDLE_W-1:0] found_handle_o,
  output logic                stored_o
);

  logic accept, push, pop, q_valid, q_full, init_busy;
  cmd_t push_cmd, pop_cmd;

  // a beat is taken whenever the queue has room and no sweep after reset runs
  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  hscl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .handle_i    (handle_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  hscl_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd),
    .full_o  (q_full)
  );

  hscl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (pop_cmd),
    .pop_o          (pop),
    .init_o         (init_busy),
    .res_strobe_o   (res_strobe_o),
    .kind_o         (kind_o),
    .hit_o          (hit_o),
    .table_full_o   (table_full_o),
    .slot_index_o   (slot_index_o),
    .found_handle_o (found_handle_o),
    .stored_o       (stored_o)
  );

`ifndef SYNTHESIS
  // queue never takes a command it has no room for
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("command queue overflow");

  // a hit always carries a nonzero handle
  a_hit_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && hit_o) |-> (found_handle_o != '0))
    else $error("hit with zero handle");

  // a full table reports no hit and slot zero
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && table_full_o) |-> (!hit_o && slot_index_o == '0))
    else $error("full result carries a slot");

  // stored flag appears only on store acknowledges
  a_stored_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && stored_o) |-> (kind_o == KIND_STORE))
    else $error("stored flag on wrong result kind");
`endif

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for hashed_source_cache_lookup. Beats go in through the
// start/busy handshake. A model of the hash table inside the bench predicts
// each lookup, store and clear result. A monitor compares every strobed
// result with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hscl_pkg::*;

  localparam int unsigned SLOTS        = 128;
  localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01b3;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned TAIL_CYCLES  = 400;
  localparam int unsigned RANDOM_BEATS = 660;
  localparam int unsigned QUIET_BEATS  = 100;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned MAX_SRC_LEN  = 6;

  typedef struct packed {
    logic [1:0]          kind;
    logic                hit;
    logic                full;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                stored;
  } cache_result_t;

  // DUT connections
  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic [1:0]          func_i       = FUNC_BYTE;
  logic [7:0]          data_byte_i  = '0;
  logic                last_i       = 1'b0;
  logic [HANDLE_W-1:0] handle_i     = '0;
  logic                res_strobe_o;
  logic [1:0]          kind_o;
  logic                hit_o;
  logic                table_full_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [HANDLE_W-1:0] found_handle_o;
  logic                stored_o;

  // Model of the cache
  logic [63:0]         src_hash;
  logic [63:0]         tbl_keys [SLOTS];
  logic [HANDLE_W-1:0] tbl_handles [SLOTS];
  logic [63:0]         pend_key;
  logic [SLOT_W-1:0]   pend_slot;
  logic                pend_ok;

  cache_result_t due_results [$];
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;
  int unsigned   beats_sent  = 0;
  int unsigned   idle_pct    = 25;

  // Source pool for repeat lookups
  logic [7:0]  pool_bytes [POOL_SIZE][MAX_SRC_LEN];
  int unsigned pool_len [POOL_SIZE];

  hashed_source_cache_lookup dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .handle_i       (handle_i),
    .res_strobe_o   (res_strobe_o),
    .kind_o         (kind_o),
    .hit_o          (hit_o),
    .table_full_o   (table_full_o),
    .slot_index_o   (slot_index_o),
    .found_handle_o (found_handle_o),
    .stored_o       (stored_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Key mixing: fold to 32 bits, xor-shift, multiply, xor-shift
  function automatic logic [31:0] mix_key(input logic [63:0] key);
    logic [31:0] h;
    h = key[31:0] ^ key[63:32];
    h = h ^ (h >> 13);
    h = h * MIX_MULT;
    h = h ^ (h >> 15);
    return h;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_keys[i]    = '0;
      tbl_handles[i] = '0;
    end
  endtask

  // Apply one accepted beat to the model and queue any result it gives
  task automatic cache_apply_beat(input logic [1:0] f, input logic [7:0] b,
                                  input logic l, input logic [HANDLE_W-1:0] h);
    cache_result_t r;
    logic [63:0]   key;
    int unsigned   base;
    int unsigned   idx;
    bit            found;
    r = '0;
    case (f)
      FUNC_BYTE: begin
        src_hash = (src_hash ^ {56'd0, b}) * FNV_PRIME;
        if (l) begin
          key      = src_hash | KEY_TOP;
          src_hash = FNV_BASIS;
          base     = mix_key(key) % SLOTS;
          found    = 1'b0;
          idx      = 0;
          // linear probe: stop on matching key or empty slot
          for (int p = 0; p < SLOTS && !found; p++) begin
            idx   = (base + p) % SLOTS;
            found = (tbl_keys[idx] == key) || (tbl_keys[idx] == '0);
          end
          pend_key = key;
          r.kind   = KIND_LOOKUP;
          if (!found) begin
            pend_slot = '0;
            pend_ok   = 1'b0;
            r.full    = 1'b1;
          end else begin
            pend_slot = idx[SLOT_W-1:0];
            pend_ok   = 1'b1;
            r.slot    = idx[SLOT_W-1:0];
            // a matching key with a zero handle is a miss
            if (tbl_keys[idx] == key && tbl_handles[idx] != '0) begin
              r.hit    = 1'b1;
              r.handle = tbl_handles[idx];
            end
          end
          due_results.push_back(r);
        end
      end
      FUNC_STORE: begin
        r.kind = KIND_STORE;
        r.slot = pend_slot;
        if (pend_ok) begin
          tbl_keys[pend_slot]    = pend_key;
          tbl_handles[pend_slot] = h;
          r.stored               = 1'b1;
        end
        due_results.push_back(r);
      end
      FUNC_CLEAR: begin
        wipe_table();
        pend_ok = 1'b0;
        r.kind  = KIND_CLEAR;
        due_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Drive one beat, wait for the handshake, then maybe idle for a burst
  task automatic send_beat(input logic [1:0] f, input logic [7:0] b,
                           input logic l, input logic [HANDLE_W-1:0] h);
    start       <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    last_i      <= l;
    handle_i    <= h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cache_apply_beat(f, b, l, h);
    if (f != FUNC_UNUSED) beats_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Push a whole source through, last flag on the final byte
  task automatic send_source(input int unsigned sel, input bit fresh);
    int unsigned len;
    len = fresh ? $urandom_range(1, MAX_SRC_LEN) : pool_len[sel];
    for (int i = 0; i < len; i++)
      send_beat(FUNC_BYTE, fresh ? 8'($urandom) : pool_bytes[sel][i],
                i == len - 1, $urandom);
  endtask

  // Result monitor
  task automatic report_mismatch(input string what, input cache_result_t want,
                                 input cache_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d hit=%0d full=%0d slot=%0d handle=%h stored=%0d",
               want.kind, want.hit, want.full, want.slot, want.handle, want.stored);
      $display("  actual   kind=%0d hit=%0d full=%0d slot=%0d handle=%h stored=%0d",
               got.kind, got.hit, got.full, got.slot, got.handle, got.stored);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    cache_result_t got;
    cache_result_t want;
    if (res_strobe_o === 1'b1) begin
      got = {kind_o, hit_o, table_full_o, slot_index_o, found_handle_o, stored_o};
      if (due_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) report_mismatch("result beat mismatch", want, got);
      end
    end
  end

  // Hand-picked corner cases
  task automatic test_directed();
    // store with nothing pending
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h1234_5678);
    // zero byte source: miss, store all-ones, then hit
    send_beat(FUNC_BYTE, 8'h00, 1'b1, '0);
    send_beat(FUNC_STORE, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_beat(FUNC_BYTE, 8'h00, 1'b1, '0);
    // overwrite after a hit with handle zero: key stays, never hits
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h0000_0000);
    send_beat(FUNC_BYTE, 8'h00, 1'b1, '0);
    // repeated store into the same slot
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h0000_0001);
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h8000_0000);
    send_beat(FUNC_BYTE, 8'h00, 1'b1, '0);
    // multi-byte source with an unused code in the middle
    send_beat(FUNC_BYTE, 8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_beat(FUNC_BYTE, 8'hA5, 1'b0, '0);
    send_beat(FUNC_UNUSED, 8'h5A, 1'b1, 32'hDEAD_BEEF);
    send_beat(FUNC_BYTE, 8'hFF, 1'b1, '0);
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'hA5A5_5A5A);
    // clear part way through a source keeps the running hash
    send_beat(FUNC_BYTE, 8'h12, 1'b0, '0);
    send_beat(FUNC_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h0000_0001);
    send_beat(FUNC_BYTE, 8'h34, 1'b1, '0);
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h7FFF_FFFF);
    send_beat(FUNC_BYTE, 8'h00, 1'b1, '0);
  endtask

  // Fill every slot, then look up with the table full
  task automatic test_table_full();
    send_beat(FUNC_CLEAR, 8'h00, 1'b0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      send_beat(FUNC_BYTE, 8'(i), 1'b1, $urandom);
      send_beat(FUNC_STORE, 8'($urandom), 1'b0, $urandom);
    end
    for (int i = SLOTS; i < SLOTS + 4; i++) begin
      send_beat(FUNC_BYTE, 8'(i), 1'b1, '0);
      send_beat(FUNC_STORE, 8'h00, 1'b0, 32'hCAFE_0001);
    end
    // a stored key is still found in a full table
    send_beat(FUNC_BYTE, 8'd5, 1'b1, '0);
    send_beat(FUNC_STORE, 8'h00, 1'b0, 32'h0BAD_F00D);
    send_beat(FUNC_BYTE, 8'd5, 1'b1, '0);
    send_beat(FUNC_CLEAR, 8'h00, 1'b0, '0);
  endtask

  // Mostly well-formed lookup/store pairs over a small pool, plus noise
  task automatic test_random();
    int unsigned goal;
    int unsigned pick;
    int unsigned sel;
    bit          fresh;
    logic [HANDLE_W-1:0] h;
    for (int s = 0; s < POOL_SIZE; s++) begin
      pool_len[s] = $urandom_range(1, MAX_SRC_LEN);
      for (int i = 0; i < MAX_SRC_LEN; i++) pool_bytes[s][i] = 8'($urandom);
    end
    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      // vary idling by phase, none over the closing stretch
      if (goal - beats_sent <= QUIET_BEATS) idle_pct = 0;
      else if ($urandom_range(0, 49) == 0) idle_pct = $urandom_range(0, 2) * 30;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 75) begin
        fresh = ($urandom_range(0, 4) == 0);
        send_source(sel, fresh);
        if ($urandom_range(0, 9) < 7) begin
          h = ($urandom_range(0, 9) == 0) ? '0 : HANDLE_W'($urandom);
          send_beat(FUNC_STORE, 8'($urandom), 1'($urandom), h);
        end
      end else if (pick < 85) begin
        send_beat(FUNC_STORE, 8'($urandom), 1'($urandom), $urandom);
      end else if (pick < 88) begin
        send_beat(FUNC_CLEAR, 8'($urandom), 1'($urandom), $urandom);
      end else if (pick < 93) begin
        // broken source: bytes without the last flag
        send_beat(FUNC_BYTE, 8'($urandom), 1'b0, $urandom);
      end else if (pick < 97) begin
        send_beat(FUNC_UNUSED, 8'($urandom), 1'($urandom), $urandom);
      end else begin
        send_beat(FUNC_BYTE, 8'($urandom), 1'b0, $urandom);
        send_beat(FUNC_CLEAR, 8'($urandom), 1'($urandom), $urandom);
      end
    end
  endtask

  // Main sequence
  initial begin
    src_hash  = FNV_BASIS;
    pend_key  = '0;
    pend_slot = '0;
    pend_ok   = 1'b0;
    wipe_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_table_full();
    test_random();

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/hscl_pkg.sv
design/hscl_ram.sv
design/hscl_fifo.sv
design/hscl_front.sv
design/hscl_back.sv
design/hashed_source_cache_lookup.sv
tb/sv/tb.sv
